// ===== design/sida_pkg.sv =====
// Shared constants for the signed integer to decimal ASCII converter.
// No dependencies; used by the converter and its checker.
package sida_pkg;

   // Default configuration
   localparam int VALUE_BITS_DEFAULT = 32;
   localparam int MAX_CHARS_DEFAULT  = 11;

   // Binary shifts handled by one conversion stage
   localparam int DABBLE_STEPS = 4;

   // Character codes
   localparam logic [7:0] ASCII_ZERO  = 8'd48;
   localparam logic [7:0] ASCII_NINE  = 8'd57;
   localparam logic [7:0] ASCII_MINUS = 8'd45;

endpackage

// ===== design/signed_int_to_decimal_ascii.sv =====
// Signed integer to decimal ASCII converter, top level.
// Depends on sida_pkg for character codes, default sizes and stage width.
//
// Each request carries one two's-complement integer; the block answers with
// its decimal text, one character per response, most significant first: a
// '-' for negative values, then the digits without leading zeros ('0' for
// zero), and rsp_last on the final character. The most negative value
// prints in full. Texts longer than MAX_CHARS are cut to MAX_CHARS
// characters. A request passes a capture stage, ceil(VALUE_BITS/4) shift-
// and-add-3 stages (four binary bits each), a formatting stage, the
// emitter and the output register. The single output register sets the
// rate: one character per cycle while rsp_stall is low, an item taking
// 1 to MAX_CHARS characters, back to back with the next item. Requests
// keep entering the pipeline while the output drains, up to one per stage.
module signed_int_to_decimal_ascii #(
   parameter int VALUE_BITS = sida_pkg::VALUE_BITS_DEFAULT,
   parameter int MAX_CHARS  = sida_pkg::MAX_CHARS_DEFAULT
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   output logic                         req_stall,
   input  logic signed [VALUE_BITS-1:0] req_number,
   output logic                         rsp_valid,
   input  logic                         rsp_stall,
   output logic [7:0]                   rsp_char_code,
   output logic                         rsp_last
);

   localparam int MB     = VALUE_BITS;                          // magnitude bits
   localparam int ND     = (VALUE_BITS * 30103) / 100000 + 1;   // decimal digits
   localparam int DW     = 4 * ND;
   localparam int WW     = DW + MB;
   localparam int STEPS  = sida_pkg::DABBLE_STEPS;
   localparam int NS     = (MB + STEPS - 1) / STEPS;
   localparam int NDW    = $clog2(ND + 1);
   localparam int IDX_W  = $clog2(ND);
   localparam int CW     = $clog2(MAX_CHARS + 1);

   // One group of shift-and-add-3 steps on {bcd, binary}
   function automatic logic [WW-1:0] dabble(input logic [WW-1:0] w_in, input int steps);
      logic [WW-1:0] w;
      w = w_in;
      for (int j = 0; j < STEPS; j++) begin
         if (j < steps) begin
            for (int d = 0; d < ND; d++) begin
               if (w[MB+4*d +: 4] >= 4'd5) begin
                  w[MB+4*d +: 4] = w[MB+4*d +: 4] + 4'd3;
               end
            end
            w = {w[WW-2:0], 1'b0};
         end
      end
      return w;
   endfunction

   // Conversion pipeline: stage 0 captures the magnitude, 1..NS convert
   logic [WW-1:0]     word_ff [0:NS];
   logic              neg_ff  [0:NS];
   logic              vld_ff  [0:NS];
   logic              rdy     [0:NS];

   // Formatting stage
   logic              fmt_vld_ff;
   logic [ND-1:0][3:0] fmt_digits_ff;
   logic              fmt_neg_ff;
   logic [NDW-1:0]    fmt_ndig_ff;
   logic [CW-1:0]     fmt_count_ff;
   logic [NDW-1:0]    fmt_ndig_in;
   logic [CW-1:0]     fmt_count_in;
   logic [NDW:0]      fmt_total;
   logic              fmt_rdy;

   // Character emitter and output register
   logic              busy_ff, busy_in;
   logic [ND-1:0][3:0] digits_ff, digits_in;
   logic              minus_ff, minus_in;
   logic [IDX_W-1:0]  idx_ff, idx_in;
   logic [CW-1:0]     left_ff, left_in;
   logic              rsp_valid_ff, rsp_valid_in;
   logic [7:0]        char_ff, char_in;
   logic              last_ff, last_in;
   logic              out_free, emit, emit_last, load;

   logic [VALUE_BITS-1:0] mag_in;

   // Walk the ready chain back from the emitter
   always_comb begin
      fmt_rdy = !fmt_vld_ff || load;
      rdy[NS] = !vld_ff[NS] || fmt_rdy;
      for (int s = NS - 1; s >= 0; s--) begin
         rdy[s] = !vld_ff[s] || rdy[s+1];
      end
   end

   assign req_stall = !rdy[0];

   // Capture the request as sign and magnitude
   assign mag_in = req_number[VALUE_BITS-1] ? (~req_number + 1'b1) : req_number;

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff[0] <= 1'b0;
      end else if (rdy[0]) begin
         vld_ff[0] <= req_valid;
      end
      if (rdy[0]) begin
         word_ff[0] <= {{DW{1'b0}}, mag_in};
         neg_ff[0]  <= req_number[VALUE_BITS-1];
      end
   end

   // Convert binary to BCD, STEPS bits per stage
   for (genvar s = 1; s <= NS; s++) begin : g_dabble
      localparam int SN = (MB - (s - 1) * STEPS < STEPS) ? MB - (s - 1) * STEPS : STEPS;
      always_ff @(posedge clock) begin
         if (reset) begin
            vld_ff[s] <= 1'b0;
         end else if (rdy[s]) begin
            vld_ff[s] <= vld_ff[s-1];
         end
         if (rdy[s]) begin
            word_ff[s] <= dabble(word_ff[s-1], SN);
            neg_ff[s]  <= neg_ff[s-1];
         end
      end
   end

   // Count significant digits and the characters to emit
   always_comb begin
      fmt_ndig_in = NDW'(1);
      for (int d = 0; d < ND; d++) begin
         if (word_ff[NS][MB+4*d +: 4] != 4'd0) begin
            fmt_ndig_in = NDW'(d + 1);
         end
      end
      fmt_total = {1'b0, fmt_ndig_in} + (NDW+1)'(neg_ff[NS]);
      if (int'(fmt_total) > MAX_CHARS) begin
         fmt_count_in = CW'(MAX_CHARS);
      end else begin
         fmt_count_in = CW'(fmt_total);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fmt_vld_ff <= 1'b0;
      end else if (fmt_rdy) begin
         fmt_vld_ff <= vld_ff[NS];
      end
      if (fmt_rdy) begin
         fmt_digits_ff <= word_ff[NS][WW-1:MB];
         fmt_neg_ff    <= neg_ff[NS];
         fmt_ndig_ff   <= fmt_ndig_in;
         fmt_count_ff  <= fmt_count_in;
      end
   end

   // Emit one character per free output slot; load the next request when idle or on the last
   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign emit      = busy_ff && out_free;
   assign emit_last = emit && (left_ff == CW'(1));
   assign load      = fmt_vld_ff && (!busy_ff || emit_last);

   always_comb begin
      busy_in      = busy_ff;
      digits_in    = digits_ff;
      minus_in     = minus_ff;
      idx_in       = idx_ff;
      left_in      = left_ff;
      rsp_valid_in = rsp_valid_ff;
      char_in      = char_ff;
      last_in      = last_ff;
      if (out_free) begin
         rsp_valid_in = emit;
         char_in      = minus_ff ? sida_pkg::ASCII_MINUS
                                 : sida_pkg::ASCII_ZERO + {4'd0, digits_ff[idx_ff]};
         last_in      = (left_ff == CW'(1));
      end
      if (emit) begin
         if (minus_ff) begin
            minus_in = 1'b0;
         end else begin
            idx_in = idx_ff - 1'b1;
         end
         left_in = left_ff - 1'b1;
         if (left_ff == CW'(1)) begin
            busy_in = 1'b0;
         end
      end
      if (load) begin
         busy_in   = 1'b1;
         digits_in = fmt_digits_ff;
         minus_in  = fmt_neg_ff;
         idx_in    = IDX_W'(fmt_ndig_ff - 1'b1);
         left_in   = fmt_count_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         busy_ff      <= busy_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      digits_ff <= digits_in;
      minus_ff  <= minus_in;
      idx_ff    <= idx_in;
      left_ff   <= left_in;
      char_ff   <= char_in;
      last_ff   <= last_in;
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_char_code = char_ff;
   assign rsp_last      = last_ff;

endmodule

// ===== design/sida_checker.sv =====
// Port-level checker for the signed integer to decimal ASCII converter.
// Depends on sida_pkg for character codes; bound to the top level below.
module sida_checker (
   input logic       clock,
   input logic       reset,
   input logic       rsp_valid,
   input logic       rsp_stall,
   input logic [7:0] rsp_char_code,
   input logic       rsp_last
);

   logic rsp_take;
   logic mid_ff, mid_in;

   // Track whether the next character is inside a text
   assign rsp_take = rsp_valid && !rsp_stall;

   always_comb begin
      mid_in = mid_ff;
      if (rsp_take) begin
         mid_in = !rsp_last;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mid_ff <= 1'b0;
      end else begin
         mid_ff <= mid_in;
      end
   end

   // Hold a stalled response
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_char_code) && $stable(rsp_last))
      else $error("stalled response changed");

   // Send only a minus sign or a digit
   a_char_set: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_char_code == sida_pkg::ASCII_MINUS) ||
                    ((rsp_char_code >= sida_pkg::ASCII_ZERO) &&
                     (rsp_char_code <= sida_pkg::ASCII_NINE)))
      else $error("response is not a sign or digit");

   // Place a minus sign only first, never alone
   a_minus_first: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_char_code == sida_pkg::ASCII_MINUS) |-> !mid_ff && !rsp_last)
      else $error("minus sign out of place");

   // Drop leading zeros: a zero at the start must be the whole text
   a_no_lead_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !mid_ff && (rsp_char_code == sida_pkg::ASCII_ZERO) |-> rsp_last)
      else $error("leading zero in text");

endmodule

bind signed_int_to_decimal_ascii sida_checker u_sida_checker (
   .clock         (clock),
   .reset         (reset),
   .rsp_valid     (rsp_valid),
   .rsp_stall     (rsp_stall),
   .rsp_char_code (rsp_char_code),
   .rsp_last      (rsp_last)
);
